// File: rtl/swrl_pkg.sv
// Shared types and constants for the sliding-window rate limiter.
// No dependencies; swrl_ctrl and the top level in rtl/ import this package.
`timescale 1ns / 1ps
`default_nettype none

package swrl_pkg;

  localparam int NOW_W     = 32;
  localparam int WINDOW_W  = 32;
  localparam int MAXCNT_W  = 5;
  localparam int CHAN_W    = 3;
  localparam int HELD_W    = 5;
  localparam int SLACK_W   = 16;

  localparam logic [SLACK_W-1:0] SLACK_RESET = 16'd10;

  localparam int HISTORY_DEPTH_DEFAULT = 16;
  localparam int CHANNEL_COUNT_DEFAULT = 5;

  // out-of-range channels land here (death effect), or on the last channel
  localparam int FALLBACK_CHANNEL = 3;

  typedef struct packed {
    logic [NOW_W-1:0]    now;
    logic [WINDOW_W-1:0] window;
    logic [MAXCNT_W-1:0] max_count;
    logic [CHAN_W-1:0]   channel;
  } in_beat_t;

  typedef struct packed {
    logic              pass;
    logic [HELD_W-1:0] held_count;
  } out_beat_t;

endpackage

`default_nettype wire

// File: rtl/swrl_hist_mem.sv
// Timestamp history memory: one write port, one read port, registered read.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module swrl_hist_mem #(
  parameter int WORDS  = 80,
  parameter int ADDR_W = 7,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] ram_r [WORDS];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram_r[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ram_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/swrl_ctrl.sv
// Request sequencer: count table, backward-jump check, stale scan, append.
// Depends on swrl_pkg; drives the ports of swrl_hist_mem.
`timescale 1ns / 1ps
`default_nettype none

module swrl_ctrl #(
  parameter int HISTORY_DEPTH = swrl_pkg::HISTORY_DEPTH_DEFAULT,
  parameter int CHANNEL_COUNT = swrl_pkg::CHANNEL_COUNT_DEFAULT,
  parameter int ADDR_W        = 7
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [swrl_pkg::SLACK_W-1:0] slack,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire swrl_pkg::in_beat_t           in_beat,
  output      logic                         res_valid,
  input  wire logic                         res_ready,
  output      swrl_pkg::out_beat_t          res_beat,
  output      logic                         rd_en,
  output      logic [ADDR_W-1:0]            rd_addr,
  input  wire logic [swrl_pkg::NOW_W-1:0]   rd_data,
  output      logic                         wr_en,
  output      logic [ADDR_W-1:0]            wr_addr,
  output      logic [swrl_pkg::NOW_W-1:0]   wr_data
);

  import swrl_pkg::*;

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CH_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_JUMP = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [NOW_W-1:0]    now_r, now_nxt;
  logic [WINDOW_W-1:0] win_r, win_nxt;
  logic [CNT_W-1:0]    lim_r, lim_nxt;
  logic [CH_W-1:0]     ch_r, ch_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic                en_r, en_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    cnt_tab_r [CHANNEL_COUNT];

  logic [CH_W-1:0]     ch_sel;
  logic [ADDR_W-1:0]   base_sel;
  logic [CNT_W-1:0]    cnt_in;
  logic [CNT_W-1:0]    cnt_in_dec;
  logic [CNT_W-1:0]    cnt_dec;
  logic [IDX_W-1:0]    top_idx;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    wr_idx;
  logic [NOW_W:0]      age;
  logic                stale;
  logic                jump;
  logic                append;
  logic                tab_we;
  logic [CNT_W-1:0]    cnt_fin;

  // channel fold for out-of-range numbers
  always_comb begin
    if (32'(in_beat.channel) < CHANNEL_COUNT) begin
      ch_sel = CH_W'(in_beat.channel);
    end else if (FALLBACK_CHANNEL < CHANNEL_COUNT) begin
      ch_sel = CH_W'(FALLBACK_CHANNEL);
    end else begin
      ch_sel = CH_W'(CHANNEL_COUNT - 1);
    end
  end

  assign base_sel   = ADDR_W'(32'(ch_sel) * HISTORY_DEPTH);
  assign cnt_in     = cnt_tab_r[ch_sel];
  assign cnt_in_dec = cnt_in - CNT_W'(1);
  assign cnt_dec    = cnt_r - CNT_W'(1);
  assign top_idx    = cnt_dec[IDX_W-1:0];

  // signed age: an entry later than now is never stale
  assign age   = {1'b0, now_r} - {1'b0, rd_data};
  assign stale = !age[NOW_W] && (age[NOW_W-1:0] > win_r);
  assign jump  = ({1'b0, now_r} + (NOW_W+1)'(slack)) < {1'b0, rd_data};

  assign append  = en_r && (cnt_r < lim_r);
  assign cnt_fin = append ? cnt_r + CNT_W'(1) : cnt_r;

  always_comb begin
    state_nxt = state_r;
    now_nxt   = now_r;
    win_nxt   = win_r;
    lim_nxt   = lim_r;
    ch_nxt    = ch_r;
    base_nxt  = base_r;
    en_nxt    = en_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    rd_en     = 1'b0;
    rd_idx    = idx_r;
    wr_en     = 1'b0;
    wr_idx    = idx_r;
    wr_data   = now_r;
    tab_we    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          now_nxt  = in_beat.now;
          win_nxt  = in_beat.window;
          lim_nxt  = (32'(in_beat.max_count) > HISTORY_DEPTH) ?
                     CNT_W'(HISTORY_DEPTH) : CNT_W'(in_beat.max_count);
          ch_nxt   = ch_sel;
          base_nxt = base_sel;
          en_nxt   = (in_beat.window != '0) && (in_beat.max_count != '0);
          cnt_nxt  = cnt_in;
          if (en_nxt && (cnt_in != '0)) begin
            rd_en     = 1'b1;
            rd_idx    = cnt_in_dec[IDX_W-1:0];
            state_nxt = S_JUMP;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_JUMP: begin
        // rd_data is the last entry, which is also the first one scanned
        if (jump) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = top_idx;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (stale && (idx_r != top_idx)) begin
          rd_en     = 1'b1;
          rd_idx    = top_idx;
          state_nxt = S_MOVE;
        end else begin
          if (stale) begin
            cnt_nxt = cnt_dec;
          end
          if (idx_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            rd_en     = 1'b1;
            rd_idx    = idx_r - IDX_W'(1);
            state_nxt = S_CHK;
          end
        end
      end
      S_MOVE: begin
        // last entry fills the stale slot; next read is a lower address
        wr_en   = 1'b1;
        wr_idx  = idx_r;
        wr_data = rd_data;
        cnt_nxt = cnt_dec;
        if (idx_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r - IDX_W'(1);
          rd_en     = 1'b1;
          rd_idx    = idx_r - IDX_W'(1);
          state_nxt = S_CHK;
        end
      end
      S_FIN: begin
        if (res_ready) begin
          wr_en     = append;
          wr_idx    = cnt_r[IDX_W-1:0];
          wr_data   = now_r;
          tab_we    = en_r;
          cnt_nxt   = cnt_fin;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rd_addr = ((state_r == S_IDLE) ? base_sel : base_r) + ADDR_W'(rd_idx);
  assign wr_addr = base_r + ADDR_W'(wr_idx);

  assign in_ready            = (state_r == S_IDLE);
  assign res_valid           = (state_r == S_FIN);
  assign res_beat.pass       = !en_r || append;
  assign res_beat.held_count = HELD_W'(cnt_fin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int k = 0; k < CHANNEL_COUNT; k++) begin
        cnt_tab_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (tab_we) begin
        cnt_tab_r[ch_r] <= cnt_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r  <= now_nxt;
    win_r  <= win_nxt;
    lim_r  <= lim_nxt;
    ch_r   <= ch_nxt;
    base_r <= base_nxt;
    en_r   <= en_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
  end

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("history read and write hit the same entry");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (32'(cnt_r) <= HISTORY_DEPTH))
    else $error("history count above depth");

  a_move_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |-> $past(rd_en))
    else $error("move without a read of the last entry");

  a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after a result");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready && append) |-> (cnt_r < lim_r))
    else $error("append beyond the limit");

endmodule

`default_nettype wire

// File: rtl/sliding_window_rate_limiter_core.sv
// Top level of the sliding-window rate limiter: config register, result
// register, sequencer and history memory. Depends on swrl_pkg, swrl_ctrl, swrl_hist_mem.
`timescale 1ns / 1ps
`default_nettype none

// Per-channel sliding-window event limiter. Each in_ beat carries a time stamp,
// a window, a max count and a channel; one out_ beat comes back per request
// with pass and the channel's history size afterwards. A zero window or zero
// max count passes the request and leaves all history alone. Time stamps live
// in one single-port-read memory of CHANNEL_COUNT x HISTORY_DEPTH words; the
// per-channel counts are flops cleared by reset, so no clearing pass runs and
// the block takes requests right out of reset. Requests are handled one at a
// time and the memory read port sets the pace: a disabled request, or one on
// an empty channel, goes straight to its result; otherwise the sequencer reads
// the last entry for the backward-jump check and, unless time jumped back,
// scans each stored entry, moving the last entry into each stale slot. A finished
// beat sits in the output register, so the next request can be accepted while
// out_stall holds the previous result. reverse_slack (cfg_wr_data, reset 10)
// should be written only while no request is in flight.
module sliding_window_rate_limiter_core #(
  parameter int HISTORY_DEPTH = swrl_pkg::HISTORY_DEPTH_DEFAULT,
  parameter int CHANNEL_COUNT = swrl_pkg::CHANNEL_COUNT_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [swrl_pkg::SLACK_W-1:0] cfg_wr_data,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire swrl_pkg::in_beat_t           in_beat,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      swrl_pkg::out_beat_t          out_beat
);

  import swrl_pkg::*;

  localparam int WORDS  = CHANNEL_COUNT * HISTORY_DEPTH;
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [SLACK_W-1:0] slack_r;
  logic               out_valid_r;
  out_beat_t          out_beat_r;

  logic               in_ready;
  logic               res_valid;
  logic               res_ready;
  out_beat_t          res_beat;

  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [NOW_W-1:0]   rd_data;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [NOW_W-1:0]   wr_data;

  // backward-jump tolerance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slack_r <= SLACK_RESET;
    end else if (cfg_wr_en) begin
      slack_r <= cfg_wr_data;
    end
  end

  // result register: refills in the same cycle the held beat drains
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_beat_r <= res_beat;
    end
  end

  assign in_stall  = !in_ready;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  swrl_ctrl #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .ADDR_W        (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .slack     (slack_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_beat  (res_beat),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  swrl_hist_mem #(
    .WORDS  (WORDS),
    .ADDR_W (ADDR_W),
    .DATA_W (NOW_W)
  ) u_hist_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for sliding_window_rate_limiter_core: directed table, then random
// request streams, checked against a per-channel history predictor. Depends on swrl_pkg.
`timescale 1ns / 1ps

module tb;
  import swrl_pkg::*;

  localparam int DEPTH         = HISTORY_DEPTH_DEFAULT;
  localparam int CHAN_N        = CHANNEL_COUNT_DEFAULT;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;   // worst request plus margin
  localparam int PHASE_ITEMS   = 260;
  localparam int PHASE_N       = 5;
  localparam int HOLD_CYCLES   = 150;             // long receiver hold-off
  localparam int DIR_N         = 23;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [SLACK_W-1:0] cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  in_beat_t           in_beat;
  logic               out_valid;
  logic               out_stall;
  out_beat_t          out_beat;

  sliding_window_rate_limiter_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_beat   (out_beat)
  );

  // One directed request; typed = 1 means pass/held below are the expected verdict.
  typedef struct packed {
    logic [NOW_W-1:0]    now;
    logic [WINDOW_W-1:0] window;
    logic [MAXCNT_W-1:0] max_count;
    logic [CHAN_W-1:0]   channel;
    logic                typed;
    logic                pass;
    logic [HELD_W-1:0]   held;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [DIR_N] = '{
    // disabled requests on empty channels
    '{32'd100, 32'd0, 5'd5, 3'd0, 1'b1, 1'b1, 5'd0},
    '{32'd100, 32'd50, 5'd0, 3'd1, 1'b1, 1'b1, 5'd0},
    // fill channel 0 to its limit of two
    '{32'd100, 32'd50, 5'd2, 3'd0, 1'b1, 1'b1, 5'd1},
    '{32'd110, 32'd50, 5'd2, 3'd0, 1'b1, 1'b1, 5'd2},
    '{32'd120, 32'd50, 5'd2, 3'd0, 1'b1, 1'b0, 5'd2},
    // disabled request reports the count untouched
    '{32'd0, 32'd0, 5'd0, 3'd0, 1'b1, 1'b1, 5'd2},
    // stale entry swapped out, then a jump back past the slack, then one within it
    '{32'd155, 32'd50, 5'd2, 3'd0, 1'b0, 1'b0, 5'd0},
    '{32'd140, 32'd50, 5'd16, 3'd0, 1'b0, 1'b0, 5'd0},
    '{32'd130, 32'd50, 5'd16, 3'd0, 1'b0, 1'b0, 5'd0},
    // out-of-range channels share the death effect log
    '{32'd1000, 32'd10, 5'd16, 3'd5, 1'b1, 1'b1, 5'd1},
    '{32'd1001, 32'd10, 5'd16, 3'd7, 1'b1, 1'b1, 5'd2},
    '{32'd1002, 32'd10, 5'd16, 3'd3, 1'b1, 1'b1, 5'd3},
    '{32'd1003, 32'd10, 5'd16, 3'd6, 1'b1, 1'b1, 5'd4},
    // extremes of time and window, oversized max count
    '{32'd0, 32'hFFFF_FFFF, 5'd31, 3'd2, 1'b1, 1'b1, 5'd1},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 3'd2, 1'b1, 1'b1, 5'd2},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 5'd31, 3'd2, 1'b0, 1'b0, 5'd0},
    '{32'hFFFF_FFFF, 32'd1, 5'd1, 3'd4, 1'b1, 1'b1, 5'd1},
    '{32'd0, 32'd1, 5'd1, 3'd4, 1'b0, 1'b0, 5'd0},
    '{32'd0, 32'd1, 5'd1, 3'd4, 1'b0, 1'b0, 5'd0},
    '{32'd2, 32'd1, 5'd1, 3'd4, 1'b0, 1'b0, 5'd0},
    '{32'd5, 32'd1, 5'd16, 3'd1, 1'b1, 1'b1, 5'd1},
    '{32'd5, 32'd1, 5'd16, 3'd1, 1'b1, 1'b1, 5'd2},
    '{32'd6, 32'd1, 5'd16, 3'd1, 1'b0, 1'b0, 5'd0}
  };

  // predictor state: per-channel time stamp logs and fill counts
  logic [NOW_W-1:0]   chan_stamps [CHAN_N][DEPTH];
  int unsigned        chan_fill [CHAN_N];
  logic [SLACK_W-1:0] slack_shadow;

  // random stream state
  logic [NOW_W-1:0] t_base;
  int unsigned      chan_win [CHAN_N];
  int unsigned      chan_max [CHAN_N];

  out_beat_t verdict_q [$];
  int        mismatch_count;
  int        send_calm;
  int        recv_calm;

  // verdict for one request; updates the shadow logs
  function automatic out_beat_t predict_verdict(input in_beat_t b);
    int unsigned ch;
    int unsigned cnt;
    int unsigned lim;
    int          i;
    longint      age;
    logic        ok;
    out_beat_t   r;
    if (b.channel < CHAN_N) ch = b.channel;
    else if (FALLBACK_CHANNEL < CHAN_N) ch = FALLBACK_CHANNEL;
    else ch = CHAN_N - 1;
    cnt = chan_fill[ch];
    if (cnt > DEPTH) cnt = DEPTH;
    ok = 1'b1;
    if (b.window != 0 && b.max_count != 0) begin
      lim = (b.max_count > DEPTH) ? DEPTH : b.max_count;
      // backward jump; 33-bit sum, no wrap
      if (cnt > 0 && ({1'b0, b.now} + {17'd0, slack_shadow}) < {1'b0, chan_stamps[ch][cnt-1]})
        cnt = 0;
      for (i = int'(cnt) - 1; i >= 0; i--) begin
        age = longint'({32'd0, b.now}) - longint'({32'd0, chan_stamps[ch][i]});
        if (age > longint'({32'd0, b.window})) begin
          cnt--;
          chan_stamps[ch][i] = chan_stamps[ch][cnt];
        end
      end
      if (cnt >= lim) begin
        ok = 1'b0;
      end else begin
        chan_stamps[ch][cnt] = b.now;
        cnt++;
      end
      chan_fill[ch] = cnt;
    end
    r.pass       = ok;
    r.held_count = HELD_W'(cnt);
    return r;
  endfunction

  // per-beat idle draw, with occasional stretches of no idling
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic in_beat_t random_request();
    in_beat_t    b;
    int unsigned kind;
    int unsigned ch;
    int          off;
    kind   = $urandom_range(0, 99);
    t_base = t_base + $urandom_range(0, 6);
    ch     = $urandom_range(0, CHAN_N - 1);
    if ($urandom_range(0, 29) == 0) begin
      chan_win[ch] = $urandom_range(1, 400);
      chan_max[ch] = $urandom_range(1, 16);
    end
    b.now       = t_base;
    b.window    = chan_win[ch];
    b.max_count = MAXCNT_W'(chan_max[ch]);
    b.channel   = CHAN_W'(ch);
    if (kind >= 94) begin
      // pure noise over the full field ranges
      b.now       = $urandom;
      b.window    = $urandom;
      b.max_count = MAXCNT_W'($urandom_range(0, 31));
      b.channel   = CHAN_W'($urandom_range(0, 7));
    end else if (kind >= 88) begin
      b.channel = CHAN_W'($urandom_range(CHAN_N, 7));
    end else if (kind >= 80) begin
      if ($urandom_range(0, 1)) b.window = 0;
      else b.max_count = 0;
    end else if (kind >= 70) begin
      // step back, often right around the slack boundary
      if ($urandom_range(0, 1))
        off = int'(slack_shadow) + int'($urandom_range(0, 30)) - 15;
      else
        off = $urandom_range(0, 500);
      if (off < 0) off = 0;
      b.now = t_base - NOW_W'(off);
      if ($urandom_range(0, 2) == 0) t_base = b.now;
    end
    return b;
  endfunction

  // offer one beat; predict on acceptance
  task automatic push_request(input in_beat_t b, input logic typed, input out_beat_t res);
    int        gap;
    out_beat_t want;
    gap = draw_gap(send_calm);
    @(negedge clk);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_beat  = b;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = predict_verdict(b);
    if (typed) want = res;
    verdict_q.push_back(want);
  endtask

  task automatic settle_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_slack(input logic [SLACK_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en    = 1'b0;
    slack_shadow = v;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** sliding_window_rate_limiter_core: FAILED **");
    $finish;
  end

  // result side: random stalls, two long hold-offs, field-by-field compare
  initial begin
    int        gap;
    int        taken;
    out_beat_t want;
    out_stall = 1'b0;
    taken     = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      gap = draw_gap(recv_calm);
      if (taken == 100 || taken == 800) gap = HOLD_CYCLES;
      repeat (gap) begin
        out_stall = 1'b1;
        @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual pass=%0b held=%0d",
                 $time, out_beat.pass, out_beat.held_count);
        mismatch_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_beat.pass !== want.pass) begin
          $display("%0t: pass mismatch: expected %0b, actual %0b",
                   $time, want.pass, out_beat.pass);
          mismatch_count++;
        end
        if (out_beat.held_count !== want.held_count) begin
          $display("%0t: held_count mismatch: expected %0d, actual %0d",
                   $time, want.held_count, out_beat.held_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    in_beat_t           b;
    dir_row_t           row;
    out_beat_t          res;
    logic [SLACK_W-1:0] s;
    int                 k;
    int                 p;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_beat        = '0;
    slack_shadow   = SLACK_RESET;
    mismatch_count = 0;
    send_calm      = 0;
    recv_calm      = 0;
    for (k = 0; k < CHAN_N; k++) begin
      chan_fill[k] = 0;
      chan_win[k]  = $urandom_range(1, 400);
      chan_max[k]  = $urandom_range(1, 16);
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table, run with the reset slack
    for (k = 0; k < DIR_N; k++) begin
      row            = DIR_TABLE[k];
      b.now          = row.now;
      b.window       = row.window;
      b.max_count    = row.max_count;
      b.channel      = row.channel;
      res.pass       = row.pass;
      res.held_count = row.held;
      push_request(b, row.typed, res);
    end

    // random phases, each under its own slack setting
    for (p = 0; p < PHASE_N; p++) begin
      settle_idle();
      case (p)
        0: s = '0;
        1: s = '1;
        3: s = 16'd1;
        default: s = SLACK_W'($urandom);
      endcase
      write_slack(s);
      t_base = (p == 2) ? 32'hFFFF_F000 : $urandom;   // one phase runs the time base near the top of its range
      for (k = 0; k < PHASE_ITEMS; k++)
        push_request(random_request(), 1'b0, '0);
    end

    settle_idle();
    if (mismatch_count == 0)
      $display("** sliding_window_rate_limiter_core: PASSED **");
    else
      $display("** sliding_window_rate_limiter_core: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
rtl/swrl_pkg.sv
rtl/swrl_hist_mem.sv
rtl/swrl_ctrl.sv
rtl/sliding_window_rate_limiter_core.sv
bench/tb.sv
